/* design/tgf_pkg.sv */
// ----------------------------------------------------------------------------
// tgf_pkg
// Shared types, operation codes and the 6x8 font table of the text glyph
// framebuffer.
// ----------------------------------------------------------------------------
package tgf_pkg;

   localparam int DEFAULT_DISPLAY_WIDTH = 128;
   localparam int DEFAULT_DISPLAY_PAGES = 8;

   localparam logic [7:0] GLYPH_FIRST = 8'h20;
   localparam logic [7:0] GLYPH_LAST  = 8'h7E;
   localparam int         GLYPH_COLS  = 6;
   localparam int         GLYPH_COUNT = 95;
   localparam int         GLYPH_DRAWN = 5;

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic CSR_READY_INDEX = 1'b0;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] page;
      logic [7:0] column;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] next_column;
      logic [7:0] read_byte;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_en;
      logic draw_en;
      logic read_en;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   draw_ok;
      logic   sweep_last;
      logic   step_last;
   } stat_type;

   // five drawn columns per glyph, leftmost column in the top byte
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
      40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
      40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000,
      40'h0041360800, 40'h08082A1C08
   };

   // column byte of a glyph; codes outside the printable range draw as space
   function automatic logic [7:0] glyph_column(input logic [7:0] code,
                                               input logic [2:0] idx);
      logic [7:0]  g;
      logic [39:0] row;
      logic [7:0]  col_byte;
      if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
         g = 8'd0;
      end else begin
         g = code - GLYPH_FIRST;
      end
      row = GLYPH_ROM[g[6:0]];
      if (idx >= 3'(GLYPH_DRAWN)) begin
         col_byte = 8'h00;
      end else begin
         col_byte = row[39 - 8 * idx -: 8];
      end
      return col_byte;
   endfunction

endpackage

/* design/tgf_ctrl.sv */
// ----------------------------------------------------------------------------
// tgf_ctrl
// Sequencer of the text glyph framebuffer: clearing sweeps, glyph writes,
// byte reads and the result strobe.
// ----------------------------------------------------------------------------
module tgf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output tgf_pkg::cmd_type  cmd,
   input  tgf_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_DRAW,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clear_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               tgf_pkg::OP_DRAW: begin
                  if (stat.draw_ok) begin
                     state_in = S_DRAW;
                  end else begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end
               tgf_pkg::OP_CLEAR: begin
                  state_in = S_CLEAR;
               end
               tgf_pkg::OP_READ: begin
                  // memory data lands at this edge
                  cmd.read_en  = 1'b1;
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
               default: begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         S_DRAW: begin
            cmd.draw_en = 1'b1;
            if (stat.step_last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.sweep_last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted word did not raise busy");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !(cmd.clear_en || cmd.draw_en))
      else $error("memory write while idle");

   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy out of step with state");
`endif

endmodule

/* design/tgf_dpath.sv */
// ----------------------------------------------------------------------------
// tgf_dpath
// Datapath of the text glyph framebuffer: request registers, frame memory,
// address generation, sweep and glyph step counters, result fields.
// ----------------------------------------------------------------------------
module tgf_dpath #(
   parameter int DISPLAY_WIDTH = tgf_pkg::DEFAULT_DISPLAY_WIDTH,
   parameter int DISPLAY_PAGES = tgf_pkg::DEFAULT_DISPLAY_PAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               display_ready,
   input  tgf_pkg::req_type   req_data,
   input  tgf_pkg::cmd_type   cmd,
   output tgf_pkg::stat_type  stat,
   output tgf_pkg::rsp_type   rsp_data
);

   localparam int DEPTH  = DISPLAY_WIDTH * DISPLAY_PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PAGE_W = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
   localparam int SUM_W  = ((ADDR_W > 8) ? ADDR_W : 8) + 2;
   localparam logic [8:0]        WIDTH_9  = 9'(DISPLAY_WIDTH);
   localparam logic [8:0]        PAGES_9  = 9'(DISPLAY_PAGES);
   localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);
   localparam logic [2:0]        LAST_STEP = 3'(tgf_pkg::GLYPH_COLS - 1);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_ff;

   tgf_pkg::req_type  req_ff;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [2:0]        step_ff, step_in;

   logic              in_range;
   logic              col_fit;
   logic [SUM_W-1:0]  addr_sum;
   logic [ADDR_W-1:0] addr;
   logic              we;
   logic [7:0]        wdata;

   assign in_range = ({1'b0, req_ff.page} < PAGES_9) && ({1'b0, req_ff.column} < WIDTH_9);
   assign col_fit  = ({1'b0, req_ff.column} + 9'(step_ff)) < WIDTH_9;

   assign addr_sum = SUM_W'(req_ff.page[PAGE_W-1:0]) * SUM_W'(DISPLAY_WIDTH)
                   + SUM_W'(req_ff.column) + SUM_W'(step_ff);

   assign addr  = cmd.clear_en ? sweep_ff : addr_sum[ADDR_W-1:0];
   assign we    = cmd.clear_en || (cmd.draw_en && col_fit);
   assign wdata = cmd.clear_en ? 8'h00
                               : tgf_pkg::glyph_column(req_ff.character, step_ff);

   // counters wrap to zero at the end of each pass
   assign sweep_in = (sweep_ff == LAST_ADR) ? '0 : sweep_ff + 1'b1;
   assign step_in  = (step_ff == LAST_STEP) ? '0 : step_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.clear_en) begin
            sweep_ff <= sweep_in;
         end
         if (cmd.draw_en) begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (cmd.read_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign stat.op         = tgf_pkg::op_type'(req_ff.operation);
   assign stat.draw_ok    = display_ready && in_range;
   assign stat.sweep_last = (sweep_ff == LAST_ADR);
   assign stat.step_last  = (step_ff == LAST_STEP);

   always_comb begin
      rsp_data = '0;
      case (tgf_pkg::op_type'(req_ff.operation))
         tgf_pkg::OP_DRAW: begin
            rsp_data.next_column = stat.draw_ok
                                 ? req_ff.column + 8'(tgf_pkg::GLYPH_COLS)
                                 : req_ff.column;
         end
         tgf_pkg::OP_READ: begin
            rsp_data.read_byte = in_range ? rd_ff : 8'h00;
         end
         default: begin
            rsp_data = '0;
         end
      endcase
   end

endmodule

/* design/text_glyph_framebuffer.sv */
// ----------------------------------------------------------------------------
// text_glyph_framebuffer
// Page-mode monochrome frame store with a built-in 6x8 text font.
// ----------------------------------------------------------------------------
// Commands are taken when req_start is high and req_busy is low; each one
// gives a single result word, strobed on rsp_valid for one cycle, which the
// receiver must take as it comes. The frame memory is single ported, so the
// cost of a command is set by its memory accesses: a draw that passes the
// ready and range checks goes from the decode state through six glyph
// column steps, one per cycle, each writing its column if it fits on the
// line; a read, a rejected draw or the unused code is answered from the
// decode state, and a clear sweeps the memory one byte a cycle. The next
// command may be accepted in the cycle that the result is strobed. After
// reset the same sweep zeroes the memory with req_busy high; the ready
// register may be written meanwhile.
// ----------------------------------------------------------------------------
module text_glyph_framebuffer #(
   parameter int DISPLAY_WIDTH = tgf_pkg::DEFAULT_DISPLAY_WIDTH,
   parameter int DISPLAY_PAGES = tgf_pkg::DEFAULT_DISPLAY_PAGES
) (
   input  logic             clock,
   input  logic             reset,

   input  logic             req_start,
   output logic             req_busy,
   input  tgf_pkg::req_type req_data,

   output logic             rsp_valid,
   output tgf_pkg::rsp_type rsp_data,

   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   tgf_pkg::cmd_type  cmd;
   tgf_pkg::stat_type stat;
   logic              ready_ff;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == tgf_pkg::CSR_READY_INDEX) begin
         ready_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == tgf_pkg::CSR_READY_INDEX)
                     ? {31'd0, ready_ff} : 32'd0;

   tgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_start),
      .busy      (req_busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   tgf_dpath #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_PAGES (DISPLAY_PAGES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .display_ready (ready_ff),
      .req_data      (req_data),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_data      (rsp_data)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Command-level check of the text glyph framebuffer. Drawn glyphs, clears
// and byte reads are predicted on a private image of the frame store, and
// every result word is compared field by field with the oldest prediction.
// A directed sequence covers the edges first, then random commands run under
// several ready settings and sender idle rates.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WIDTH       = tgf_pkg::DEFAULT_DISPLAY_WIDTH;
   localparam int PAGES       = tgf_pkg::DEFAULT_DISPLAY_PAGES;
   localparam int QUIET_LIMIT = 6000;
   localparam logic [2:0] READY_ADDR = 3'(4 * tgf_pkg::CSR_READY_INDEX);

   // five drawn columns per printable code, leftmost column in the top byte
   localparam logic [39:0] FONT_TABLE [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
      40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
      40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000,
      40'h0041360800, 40'h08082A1C08
   };

   logic             clock;
   logic             reset        = 1'b1;
   logic             req_start    = 1'b0;
   logic             req_busy;
   tgf_pkg::req_type req_data     = '0;
   logic             rsp_valid;
   tgf_pkg::rsp_type rsp_data;
   logic             csr_psel     = 1'b0;
   logic             csr_penable  = 1'b0;
   logic             csr_pwrite   = 1'b0;
   logic [2:0]       csr_paddr    = '0;
   logic [31:0]      csr_pwdata   = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   tgf_pkg::req_type pending_cmds [$];
   tgf_pkg::rsp_type expected_rsps [$];
   logic [7:0]       frame_image [PAGES * WIDTH];
   bit               ready_shadow = 1'b0;
   logic             req_taken    = 1'b0;
   int               idle_pct     = 0;
   int               fail_count   = 0;
   int               quiet_cycles = 0;
   logic [7:0]       last_page    = '0;
   logic [7:0]       last_col     = '0;

   text_glyph_framebuffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_busy    (req_busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic logic [7:0] font_byte(input logic [7:0] code, input int idx);
      logic [39:0] cols;
      cols = FONT_TABLE[0];
      if (code >= tgf_pkg::GLYPH_FIRST && code <= tgf_pkg::GLYPH_LAST) begin
         cols = FONT_TABLE[code - tgf_pkg::GLYPH_FIRST];
      end
      if (idx >= tgf_pkg::GLYPH_DRAWN) begin
         return 8'h00;
      end
      return 8'((cols >> (8 * (tgf_pkg::GLYPH_DRAWN - 1 - idx))) & 40'hFF);
   endfunction

   // advance the private frame image by one command and give its result word
   function automatic tgf_pkg::rsp_type apply_command(input tgf_pkg::req_type w);
      tgf_pkg::rsp_type r;
      int               base;
      bit               on_screen;
      r = '0;
      on_screen = (w.page < PAGES) && (w.column < WIDTH);
      base = int'(w.page) * WIDTH + int'(w.column);
      case (tgf_pkg::op_type'(w.operation))
         tgf_pkg::OP_DRAW: begin
            if (ready_shadow && on_screen) begin
               for (int k = 0; k < tgf_pkg::GLYPH_COLS; k++) begin
                  if (int'(w.column) + k < WIDTH) begin
                     frame_image[base + k] = font_byte(w.character, k);
                  end
               end
               r.next_column = w.column + 8'(tgf_pkg::GLYPH_COLS);
            end else begin
               r.next_column = w.column;
            end
         end
         tgf_pkg::OP_CLEAR: begin
            foreach (frame_image[k]) frame_image[k] = 8'h00;
         end
         tgf_pkg::OP_READ: begin
            if (on_screen) begin
               r.read_byte = frame_image[base];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic tgf_pkg::req_type command(input tgf_pkg::op_type op,
                                                input logic [7:0] page,
                                                input logic [7:0] column,
                                                input logic [7:0] character);
      tgf_pkg::req_type w;
      w.operation = op;
      w.page      = page;
      w.column    = column;
      w.character = character;
      return w;
   endfunction

   // mostly on-screen draws and reads of recently drawn columns, some noise
   function automatic tgf_pkg::req_type random_command();
      tgf_pkg::req_type w;
      int               pick;
      tgf_pkg::op_type  op;
      pick = $urandom_range(99);
      w.character = 8'($urandom_range(255));
      if (pick < 55) begin
         w.operation = tgf_pkg::OP_DRAW;
         w.page = 8'($urandom_range(PAGES - 1));
         if ($urandom_range(4) == 0) begin
            w.column = 8'($urandom_range(WIDTH - 1, WIDTH - 10));
         end else begin
            w.column = 8'($urandom_range(WIDTH - 1));
         end
         if ($urandom_range(9) != 0) begin
            w.character = 8'($urandom_range(tgf_pkg::GLYPH_LAST, tgf_pkg::GLYPH_FIRST));
         end
         last_page = w.page;
         last_col  = w.column;
      end else if (pick < 80) begin
         w.operation = tgf_pkg::OP_READ;
         if ($urandom_range(9) < 6) begin
            w.page   = last_page;
            w.column = last_col + 8'($urandom_range(tgf_pkg::GLYPH_COLS));
         end else begin
            w.page   = 8'($urandom_range(PAGES - 1));
            w.column = 8'($urandom_range(WIDTH - 1));
         end
      end else if (pick < 81) begin
         w.operation = tgf_pkg::OP_CLEAR;
         w.page      = 8'($urandom_range(255));
         w.column    = 8'($urandom_range(255));
      end else begin
         case ($urandom_range(2))
            0:       op = tgf_pkg::OP_DRAW;
            1:       op = tgf_pkg::OP_READ;
            default: op = tgf_pkg::OP_NONE;
         endcase
         w.operation = op;
         w.page      = 8'($urandom_range(255));
         w.column    = 8'($urandom_range(255));
      end
      return w;
   endfunction

   task automatic drain();
      while (pending_cmds.size() != 0 || req_start || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // write the ready register, then read it back
   task automatic program_ready(input bit v);
      logic [31:0] seen;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= READY_ADDR;
      csr_pwdata  <= ($urandom() & 32'hFFFF_FFFE) | 32'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      ready_shadow = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== 32'(v)) begin
         report($sformatf("ready register reads %h, wrote %0d", seen, v));
      end
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         pending_cmds.push_back(random_command());
      end
      drain();
   endtask

   // driver: hold the word until it is taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (!req_start || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_start <= 1'b1;
            req_data  <= pending_cmds.pop_front();
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   // monitor: check result words, predict accepted commands, watch for a hang
   always @(posedge clock) begin
      tgf_pkg::rsp_type want;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            moved = 1'b1;
            if (expected_rsps.size() == 0) begin
               report($sformatf("unexpected result word %h", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.next_column !== want.next_column) begin
                  report($sformatf("next_column %h, predicted %h",
                                   rsp_data.next_column, want.next_column));
               end
               if (rsp_data.read_byte !== want.read_byte) begin
                  report($sformatf("read_byte %h, predicted %h",
                                   rsp_data.read_byte, want.read_byte));
               end
            end
         end
         if (req_start && req_busy === 1'b0) begin
            moved = 1'b1;
            expected_rsps.push_back(apply_command(req_data));
         end
         if (csr_psel && csr_penable && csr_pready === 1'b1) begin
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
      req_taken <= req_start && req_busy === 1'b0 && !reset;
   end

   initial begin
      foreach (frame_image[k]) frame_image[k] = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // not ready: draws bounce, reads still answer
      program_ready(1'b0);
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd0, 8'd0, 8'h41));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd0, 8'd0, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd3, 8'd100, 8'h41));
      drain();

      // ready: edges, clipping, non-printable codes, rejected positions
      program_ready(1'b1);
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd0, 8'd0, 8'h41));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd0, 8'd0, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd0, 8'd5, 8'hFF));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd7, 8'd127, 8'h7E));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd7, 8'd127, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd3, 8'd124, 8'h7E));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd3, 8'd126, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd1, 8'd10, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd1, 8'd16, 8'hFF));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd1, 8'd22, 8'h7F));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd2, 8'd30, 8'h20));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd2, 8'd36, 8'h1F));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd8, 8'd0, 8'h41));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd0, 8'd128, 8'h41));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd255, 8'd255, 8'hFF));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd8, 8'd0, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd255, 8'd255, 8'hFF));
      pending_cmds.push_back(command(tgf_pkg::OP_NONE, 8'd255, 8'd255, 8'hFF));
      drain();

      // not ready again: stored bytes still readable, clear still works
      program_ready(1'b0);
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd0, 8'd1, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_DRAW, 8'd0, 8'd0, 8'h42));
      pending_cmds.push_back(command(tgf_pkg::OP_CLEAR, 8'd0, 8'd0, 8'h00));
      pending_cmds.push_back(command(tgf_pkg::OP_READ, 8'd0, 8'd1, 8'h00));
      drain();

      program_ready(1'b1);
      idle_pct = 8;
      random_phase(700);

      program_ready(1'b0);
      idle_pct = 80;
      random_phase(200);

      program_ready(1'b1);
      random_phase(300);

      idle_pct = 0;
      random_phase(600);

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
